>>> design/dcas_pkg.sv
package dcas_pkg;

    typedef enum logic [1:0] {
        OP_STEP,
        OP_LOAD,
        OP_ERROR,
        OP_DROP
    } op_kind_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_PERIPH = 3'd1;
    localparam logic [2:0] ST_BAD_FIFO   = 3'd2;
    localparam logic [2:0] ST_NO_SPECIAL = 3'd3;
    localparam logic [2:0] ST_BAD_TIMING = 3'd4;

    localparam logic [1:0] STEP_DEC  = 2'd1;
    localparam logic [1:0] STEP_HOLD = 2'd2;

    localparam logic [1:0] TIMING_IMMEDIATE = 2'd0;
    localparam logic [1:0] TIMING_SPECIAL   = 2'd3;

    localparam logic [0:0] CFG_PERIPH_BASE = 1'd0;
    localparam logic [0:0] CFG_PERIPH_SIZE = 1'd1;

    localparam logic [31:0] PERIPH_BASE_RESET = 32'h0400_0000;
    localparam logic [31:0] PERIPH_SIZE_RESET = 32'h0000_0400;

    localparam logic [31:0] FIFO_A_OFFSET   = 32'h0000_00A0;
    localparam logic [31:0] FIFO_B_OFFSET   = 32'h0000_00A4;
    localparam logic [31:0] WINDOW_LOW_OFS  = 32'h0000_0090;
    localparam logic [31:0] WINDOW_HIGH_OFS = 32'h0000_00A8;

    localparam logic [16:0] COUNT_MAX_LONG  = 17'h1_0000;
    localparam logic [16:0] COUNT_MAX_SHORT = 17'h0_4000;
    localparam logic [16:0] COUNT_SPECIAL   = 17'd4;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] src;
        logic [31:0] dst;
        logic [16:0] count;
        logic        wide;
        logic [1:0]  src_code;
        logic [1:0]  dst_code;
        logic        repeat_on;
        logic [2:0]  status;
        logic        clr;
    } op_entry_t;

endpackage

>>> design/dcas_front.sv
module dcas_front
    import dcas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        command,
    input  logic [1:0]  channel,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [31:0] control_word,
    output op_entry_t   entry
);

    logic [31:0] base_reg;
    logic [31:0] size_reg;

    logic [1:0]  timing;
    logic        rep;
    logic [16:0] count;
    logic [32:0] window_top;
    logic        in_window;
    logic [31:0] offset;
    logic        bad_offset;
    logic        fifo_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= PERIPH_BASE_RESET;
            size_reg <= PERIPH_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PERIPH_BASE: base_reg <= cfg_data;
                CFG_PERIPH_SIZE: size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        timing     = control_word[29:28];
        rep        = control_word[25];
        window_top = {1'b0, base_reg} + {1'b0, size_reg};
        in_window  = (dest_address >= base_reg) && ({1'b0, dest_address} < window_top);
        offset     = dest_address - base_reg;
        bad_offset = (offset < WINDOW_LOW_OFS) || (offset >= WINDOW_HIGH_OFS);
        fifo_match = (dest_address == base_reg + FIFO_A_OFFSET)
                  || (dest_address == base_reg + FIFO_B_OFFSET);

        if (channel == 2'd3)
        begin
            count = (control_word[15:0] == 16'd0) ? COUNT_MAX_LONG
                                                  : {1'b0, control_word[15:0]};
        end
        else
        begin
            count = (control_word[13:0] == 14'd0) ? COUNT_MAX_SHORT
                                                  : {3'b000, control_word[13:0]};
        end

        entry.src       = source_address;
        entry.dst       = dest_address;
        entry.count     = count;
        entry.wide      = control_word[26];
        entry.src_code  = control_word[24:23];
        entry.dst_code  = control_word[22:21];
        entry.repeat_on = rep;
        entry.status    = ST_OK;
        entry.clr       = 1'b0;

        if (command)
        begin
            entry.kind = OP_STEP;
        end
        else if (!control_word[31])
        begin
            entry.kind = OP_DROP;
        end
        else if (timing == TIMING_IMMEDIATE)
        begin
            if (in_window && bad_offset)
            begin
                entry.kind   = OP_ERROR;
                entry.status = ST_BAD_PERIPH;
            end
            else
            begin
                entry.kind = OP_LOAD;
            end
        end
        else if (timing == TIMING_SPECIAL)
        begin
            if (channel != 2'd1 && channel != 2'd2)
            begin
                entry.kind   = OP_ERROR;
                entry.status = ST_NO_SPECIAL;
                entry.clr    = !rep;
            end
            else if (!fifo_match)
            begin
                entry.kind   = OP_ERROR;
                entry.status = ST_BAD_FIFO;
                entry.clr    = !rep;
            end
            else
            begin
                entry.kind     = OP_LOAD;
                entry.count    = COUNT_SPECIAL;
                entry.wide     = 1'b1;
                entry.dst_code = STEP_HOLD;
            end
        end
        else
        begin
            entry.kind   = OP_ERROR;
            entry.status = ST_BAD_TIMING;
        end
    end

endmodule

>>> design/dcas_queue.sv
module dcas_queue
    import dcas_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  op_entry_t push_entry,
    output logic      full,
    output logic      not_empty,
    input  logic      pop,
    output op_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> design/dcas_back.sv
module dcas_back
    import dcas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        deq_valid,
    input  op_entry_t   deq_entry,
    output logic        deq_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_address,
    output logic [31:0] write_address,
    output logic        word_size,
    output logic        last,
    output logic        clear_enable,
    output logic [2:0]  status
);

    logic        busy_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [16:0] units_left_reg;
    logic        wide_reg;
    logic [1:0]  src_code_reg;
    logic [1:0]  dst_code_reg;
    logic        repeat_reg;

    logic        out_valid_reg;
    logic [31:0] rd_addr_reg;
    logic [31:0] wr_addr_reg;
    logic        word_size_reg;
    logic        last_reg;
    logic        clr_reg;
    logic [2:0]  status_reg;

    logic        pop;
    logic        step_last;

    function automatic logic [31:0] advance(input logic [31:0] addr,
                                            input logic [1:0] code,
                                            input logic wide);
        logic [31:0] size;
        size = wide ? 32'd4 : 32'd2;
        if (code == STEP_DEC)
        begin
            return addr - size;
        end
        else if (code == STEP_HOLD)
        begin
            return addr;
        end
        return addr + size;
    endfunction

    assign pop           = deq_valid && (!out_valid_reg || out_ready);
    assign deq_ready     = pop;
    assign step_last     = (units_left_reg <= 17'd1);
    assign out_valid     = out_valid_reg;
    assign read_address  = rd_addr_reg;
    assign write_address = wr_addr_reg;
    assign word_size     = word_size_reg;
    assign last          = last_reg;
    assign clear_enable  = clr_reg;
    assign status        = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            src_reg        <= '0;
            dst_reg        <= '0;
            units_left_reg <= '0;
            wide_reg       <= 1'b0;
            src_code_reg   <= '0;
            dst_code_reg   <= '0;
            repeat_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                unique case (deq_entry.kind)
                    OP_STEP:
                    begin
                        if (busy_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            src_reg        <= advance(src_reg, src_code_reg, wide_reg);
                            dst_reg        <= advance(dst_reg, dst_code_reg, wide_reg);
                            units_left_reg <= step_last ? 17'd0 : units_left_reg - 17'd1;
                            busy_reg       <= !step_last;
                        end
                    end
                    OP_LOAD:
                    begin
                        busy_reg       <= 1'b1;
                        src_reg        <= deq_entry.src;
                        dst_reg        <= deq_entry.dst;
                        units_left_reg <= deq_entry.count;
                        wide_reg       <= deq_entry.wide;
                        src_code_reg   <= deq_entry.src_code;
                        dst_code_reg   <= deq_entry.dst_code;
                        repeat_reg     <= deq_entry.repeat_on;
                    end
                    OP_ERROR:
                    begin
                        busy_reg      <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                    OP_DROP:
                    begin
                        busy_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (deq_entry.kind == OP_STEP)
            begin
                rd_addr_reg   <= src_reg;
                wr_addr_reg   <= dst_reg;
                word_size_reg <= wide_reg;
                last_reg      <= step_last;
                clr_reg       <= step_last && !repeat_reg;
                status_reg    <= ST_OK;
            end
            else if (deq_entry.kind == OP_ERROR)
            begin
                rd_addr_reg   <= '0;
                wr_addr_reg   <= '0;
                word_size_reg <= 1'b0;
                last_reg      <= 1'b1;
                clr_reg       <= deq_entry.clr;
                status_reg    <= deq_entry.status;
            end
        end
    end

    a_last_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && deq_entry.kind == OP_STEP && busy_reg && step_last) |=> !busy_reg)
        else $error("transfer still busy after its final unit");

    a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && deq_entry.kind == OP_LOAD) |=> (busy_reg && units_left_reg != 17'd0))
        else $error("load did not arm the transfer");

    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("result appeared without a queued operation");

endmodule

>>> design/dma_channel_address_sequencer_top.sv
// Channel   Handshake                 Payload
// cfg       cfg_write                 cfg_index, cfg_data
// in        in_valid / in_ready       command, channel, source_address,
//                                     dest_address, control_word
// out       out_valid / out_ready     read_address, write_address, word_size,
//                                     last, clear_enable, status
//
// An item is classified in the cycle it is accepted and written to the operation queue.
// The back end retires one queued operation per cycle while the output is not stalled; a result,
// if the item yields one, is registered after the queue, at a sustained one item per cycle.
// Reset empties the queue and clears the channel state and the output valid flag.
// A stalled output holds the back end; the front keeps accepting until the queue fills.
module dma_channel_address_sequencer_top
    import dcas_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [1:0]  channel,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [31:0] control_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_address,
    output logic [31:0] write_address,
    output logic        word_size,
    output logic        last,
    output logic        clear_enable,
    output logic [2:0]  status
);

    op_entry_t front_entry;
    op_entry_t queue_entry;
    logic      queue_full;
    logic      queue_not_empty;
    logic      queue_pop;

    assign in_ready = !queue_full;

    dcas_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .channel        (channel),
        .source_address (source_address),
        .dest_address   (dest_address),
        .control_word   (control_word),
        .entry          (front_entry)
    );

    dcas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !queue_full),
        .push_entry (front_entry),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .pop        (queue_pop),
        .pop_entry  (queue_entry)
    );

    dcas_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .deq_valid     (queue_not_empty),
        .deq_entry     (queue_entry),
        .deq_ready     (queue_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_address  (read_address),
        .write_address (write_address),
        .word_size     (word_size),
        .last          (last),
        .clear_enable  (clear_enable),
        .status        (status)
    );

endmodule
